// ----- hw/rtl/rdh_pkg.sv -----
// Shared types and constants of the reuse distance histogram.
// Holds the item token that travels along the recency stack chain and the result record.
// No dependencies.
`default_nettype none

package rdh_pkg;

    localparam int LINE_W      = 64;
    localparam int CMD_W       = 2;
    localparam int SEL_W       = 8;
    localparam int DIST_W      = 8;
    localparam int OUT_COUNT_W = 48;
    localparam int SHIFT_W     = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARKER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MARKER = 8'd1;

    localparam logic [SHIFT_W-1:0]     LINE_SHIFT_RESET = 4'd6;
    localparam logic [DIST_W-1:0]      DIST_MAX         = 8'hFF;
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX    = {OUT_COUNT_W{1'b1}};

    // What an item asks of the histogram once it leaves the stack chain.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_ACCESS = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Token handed from cell to cell. The carry is the entry displaced so far.
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic [LINE_W-1:0] key;
        logic [LINE_W-1:0] cline;
        logic              cvld;
        logic              hit;
        logic [SEL_W-1:0]  sel;
    } t_tok;

    typedef struct packed {
        logic                   counted;
        logic [DIST_W-1:0]      distance;
        logic [OUT_COUNT_W-1:0] count;
    } t_res;

endpackage

`default_nettype wire

// ----- hw/rtl/rdh_cell.sv -----
// One entry of the recency stack with its stage of the token pipeline.
// Depends on rdh_pkg for the token type.
`default_nettype none

module rdh_cell
    import rdh_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int BIN_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire t_tok             i_tok,
    input  wire logic [BIN_W-1:0] i_pos,
    output t_tok                  o_tok,
    output logic [BIN_W-1:0]      o_pos
);

    logic [LINE_W-1:0] r_line;
    logic              r_valid;
    t_tok              r_tok;
    logic [BIN_W-1:0]  r_pos;

    t_tok              n_tok;
    logic [BIN_W-1:0]  n_pos;
    logic              w_touch;
    logic              w_match;

    // An access that has not yet found its line swaps the carry into this entry.
    assign w_touch = i_tok.vld && (i_tok.op == OP_ACCESS) && !i_tok.hit;
    assign w_match = w_touch && r_valid && (r_line == i_tok.key);

    always_comb begin
        n_tok = i_tok;
        n_pos = i_pos;
        if (w_match) begin
            n_tok.hit = 1'b1;
            n_pos     = BIN_W'(INDEX);
        end else if (w_touch) begin
            n_tok.cline = r_line;
            n_tok.cvld  = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            r_pos <= n_pos;
            if (w_touch) begin
                r_valid <= i_tok.cvld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_touch) begin
            r_line <= i_tok.cline;
        end
    end

    assign o_tok = r_tok;
    assign o_pos = r_pos;

endmodule

`default_nettype wire

// ----- hw/rtl/rdh_hist.sv -----
// Histogram counter memory with its read-modify-write stage and clearing pass after reset.
// Depends on rdh_pkg for the token and result types.
`default_nettype none

module rdh_hist
    import rdh_pkg::*;
#(
    parameter int HIST_BINS  = 256,
    parameter int COUNT_BITS = 48,
    parameter int ADDR_W     = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_tok              i_tok,
    input  wire logic [ADDR_W-1:0] i_pos,
    output logic                   o_clearing,
    output logic                   o_push,
    output t_res                   o_res
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HIST_BINS - 1);

    logic [COUNT_BITS-1:0] r_mem [HIST_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  r_clearing;
    logic [ADDR_W-1:0]     r_clr;

    logic                  r_h_vld;
    t_op                   r_h_op;
    logic [ADDR_W-1:0]     r_h_addr;
    logic                  r_h_inrange;
    logic [DIST_W-1:0]     r_h_dist;

    logic                   w_rd;
    logic                   w_wr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_inrange;
    logic [DIST_W-1:0]      w_dist;
    logic [COUNT_BITS-1:0]  w_inc;
    logic [OUT_COUNT_W-1:0] w_cnt_sat;

    assign w_rd_addr = (i_tok.op == OP_READ) ? ADDR_W'(i_tok.sel) : i_pos;
    assign w_inrange = (32'(i_tok.sel) < HIST_BINS);
    assign w_dist    = (32'(i_pos) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(i_pos);
    assign w_rd      = i_adv && i_tok.vld && !r_clearing;
    assign w_wr      = i_adv && r_h_vld && (r_h_op == OP_ACCESS);

    assign w_inc     = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
    assign w_cnt_sat = (64'(r_rd_data) > 64'(OUT_COUNT_MAX)) ?
                       OUT_COUNT_MAX : OUT_COUNT_W'(r_rd_data);

    // Items enter the chain with at least one empty stage between them, so a write never meets
    // a read in the same cycle and the read always sees the last write.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr] <= '0;
        end else if (w_wr) begin
            r_mem[r_h_addr] <= w_inc;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_h_vld    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_adv) begin
                r_h_vld <= i_tok.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_h_op      <= i_tok.op;
            r_h_addr    <= w_rd_addr;
            r_h_inrange <= w_inrange;
            r_h_dist    <= w_dist;
        end
    end

    always_comb begin
        o_res = '0;
        case (r_h_op)
            OP_ACCESS: begin
                o_res.counted  = 1'b1;
                o_res.distance = r_h_dist;
            end
            OP_READ: begin
                o_res.count = r_h_inrange ? w_cnt_sat : '0;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_push     = i_adv && r_h_vld;
    assign o_clearing = r_clearing;

    a_no_item_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clearing |-> !r_h_vld
    ) else $error("item reached the histogram during the clearing pass");

endmodule

`default_nettype wire

// ----- hw/rtl/reuse_distance_histogram.sv -----
// Top level of the LRU stack distance histogram: entry logic, cell chain, histogram, output queue.
// Depends on rdh_pkg, rdh_cell and rdh_hist.
//
// Usage. Items arrive on the input channel (i_in_valid / o_in_ready) with a command, a byte
// address and a bin select. A memory access has its line address (address shifted right by
// line_shift) looked up in a recency stack of HIST_BINS-1 cells; the position where it is
// found is its reuse distance, a miss or far reuse lands in the last bin, and that bin of
// the histogram is incremented. A marker item lets accesses through when wait_for_marker is
// set; a read item returns one bin's count. Every item gives exactly one result item on the
// output channel (o_out_valid / i_out_ready), in order.
// Configuration writes arrive on their own channel (i_cfg_valid / o_cfg_ready), which is
// always ready; the user must make them only while the block is idle, which it does not enforce.
// An accepted item is taken into the first stack cell and moves on through the other
// HIST_BINS-2 cells, then goes to the histogram read and then to the update and the push
// into the output queue. Items enter with at least one empty stage between them; that
// spacing is set by the read-modify-write of the histogram counter memory. A new item may
// enter while earlier ones are still in the chain. The cells move together, one stage a
// cycle, whenever the output queue has room.
// After reset the histogram is cleared one bin a cycle while o_in_ready stays low. When the
// receiver stalls, a two-entry output queue takes finished results; once it is full the
// whole chain holds still until a result is taken.
`default_nettype none

module reuse_distance_histogram
    import rdh_pkg::*;
#(
    parameter int HIST_BINS  = 256,
    parameter int COUNT_BITS = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [CMD_W-1:0]       i_command,
    input  wire logic [LINE_W-1:0]      i_access_address,
    input  wire logic [SEL_W-1:0]       i_bin_select,

    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_counted,
    output logic [DIST_W-1:0]           o_reuse_distance,
    output logic [OUT_COUNT_W-1:0]      o_bin_count,

    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int STACK_DEPTH = HIST_BINS - 1;
    localparam int BIN_W       = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam logic [1:0] Q_FULL = 2'd2;

    // Configuration and marker state.
    logic [SHIFT_W-1:0] r_line_shift;
    logic               r_wait_marker;
    logic               r_marker_seen;

    // High in the cycle after an item was taken, so that items enter the chain
    // with at least one empty stage between them.
    logic               r_gap;

    logic               w_adv;
    logic               w_in_acc;
    logic               w_clearing;

    t_tok               n_entry;
    t_tok               w_tok [STACK_DEPTH+1];
    logic [BIN_W-1:0]   w_pos [STACK_DEPTH+1];

    logic               w_push;
    logic               w_pop;
    t_res               w_res;
    t_res               r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_q_cnt;

    // The chain and the histogram stage move only when the output queue has room.
    assign w_adv       = (r_q_cnt != Q_FULL);
    assign o_in_ready  = w_adv && !r_gap && !w_clearing;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift  <= LINE_SHIFT_RESET;
            r_wait_marker <= 1'b0;
            r_marker_seen <= 1'b0;
            r_gap         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LINE_SHIFT:  r_line_shift  <= i_cfg_data[SHIFT_W-1:0];
                    CFG_WAIT_MARKER: r_wait_marker <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_in_acc && (i_command == CMD_MARKER)) begin
                r_marker_seen <= 1'b1;
            end
            if (w_in_acc) begin
                r_gap <= 1'b1;
            end else if (w_adv) begin
                r_gap <= 1'b0;
            end
        end
    end

    // The new line enters as the carry of cell zero, so for an access the top cell
    // ends up holding it, and the position starts at the last bin for a miss.
    always_comb begin
        n_entry       = '0;
        n_entry.vld   = w_in_acc;
        n_entry.key   = i_access_address >> r_line_shift;
        n_entry.cline = i_access_address >> r_line_shift;
        n_entry.cvld  = 1'b1;
        n_entry.sel   = i_bin_select;
        case (i_command)
            CMD_ACCESS: n_entry.op = (!r_wait_marker || r_marker_seen) ? OP_ACCESS : OP_NONE;
            CMD_READ:   n_entry.op = OP_READ;
            default:    n_entry.op = OP_NONE;
        endcase
    end

    assign w_tok[0] = n_entry;
    assign w_pos[0] = BIN_W'(STACK_DEPTH);

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        rdh_cell #(
            .INDEX (g),
            .BIN_W (BIN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .i_pos   (w_pos[g]),
            .o_tok   (w_tok[g+1]),
            .o_pos   (w_pos[g+1])
        );
    end

    rdh_hist #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_BITS (COUNT_BITS),
        .ADDR_W     (BIN_W)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_tok      (w_tok[STACK_DEPTH]),
        .i_pos      (w_pos[STACK_DEPTH]),
        .o_clearing (w_clearing),
        .o_push     (w_push),
        .o_res      (w_res)
    );

    // Two-entry output queue: it decouples the receiver's ready from the chain.
    assign o_out_valid = (r_q_cnt != 2'd0);
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign o_counted        = r_q[r_rp].counted;
    assign o_reuse_distance = r_q[r_rp].distance;
    assign o_bin_count      = r_q[r_rp].count;

    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_push |-> (r_q_cnt != Q_FULL)
    ) else $error("result pushed into a full output queue");

    a_items_spaced: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_in_acc |=> !o_in_ready
    ) else $error("items accepted in consecutive cycles");

    a_closed_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_clearing |-> !o_in_ready
    ) else $error("input open during the histogram clearing pass");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the reuse distance histogram: an LRU stack model predicts every result.
// Depends on rdh_pkg and reuse_distance_histogram; stands alone otherwise.
`timescale 1ns / 1ps

module tb;
    import rdh_pkg::*;

    localparam int HIST_BINS   = 256;
    localparam int COUNT_BITS  = 48;
    localparam int STACK_DEPTH = HIST_BINS - 1;
    localparam int STALL_LIMIT = 4000;

    // Command 3 has no meaning; it must leave everything alone.
    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 8'hFF;
    localparam logic [COUNT_BITS-1:0] TALLY_MAX    = {COUNT_BITS{1'b1}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command = '0;
    logic [LINE_W-1:0]      i_access_address = '0;
    logic [SEL_W-1:0]       i_bin_select = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_counted;
    logic [DIST_W-1:0]      o_reuse_distance;
    logic [OUT_COUNT_W-1:0] o_bin_count;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    reuse_distance_histogram #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_access_address (i_access_address),
        .i_bin_select     (i_bin_select),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_counted        (o_counted),
        .o_reuse_distance (o_reuse_distance),
        .o_bin_count      (o_bin_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Model state: the most-recently-used line stack, its valid bits, the bin
    // counters, the marker flag and a copy of both registers.
    logic [LINE_W-1:0]     mru_lines [STACK_DEPTH];
    logic                  mru_live  [STACK_DEPTH];
    logic [COUNT_BITS-1:0] dist_tally [HIST_BINS];
    logic                  marker_flag;
    logic [SHIFT_W-1:0]    shift_cfg;
    logic                  gate_cfg;

    // Results owed by the block, oldest first.
    t_res due_outcomes [$];

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int accesses_bin   = 0;
    int reg_writes     = 0;
    int deepest_dist   = 0;
    int burst_left     = 0;
    int gap_max        = 0;
    int idle_cycles    = 0;
    int rx_mode        = 0;
    int rx_hold        = 300;

    // Line address pool for the random traffic; reuse among it yields the
    // short and middle distances, fresh addresses the first touches.
    logic [LINE_W-1:0] hot_addrs [HIST_BINS];
    int                hot_count = 16;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LINE_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Works out the result of one item and moves the model state on.
    function automatic t_res lru_outcome(input logic [CMD_W-1:0] cmd,
                                         input logic [LINE_W-1:0] addr,
                                         input logic [SEL_W-1:0] sel);
        t_res              res;
        logic [LINE_W-1:0] line;
        int                pos;
        int                last;
        res = '0;
        case (cmd)
            CMD_ACCESS: begin
                if (!gate_cfg || marker_flag) begin
                    line = addr >> shift_cfg;
                    pos  = STACK_DEPTH;
                    for (int i = 0; i < STACK_DEPTH; i++) begin
                        if (pos == STACK_DEPTH && mru_live[i] && mru_lines[i] == line) begin
                            pos = i;
                        end
                    end
                    // A miss pushes the whole stack down, dropping the bottom line.
                    last = (pos < STACK_DEPTH) ? pos : STACK_DEPTH - 1;
                    for (int i = last; i > 0; i--) begin
                        mru_lines[i] = mru_lines[i-1];
                        mru_live[i]  = mru_live[i-1];
                    end
                    mru_lines[0] = line;
                    mru_live[0]  = 1'b1;
                    if (dist_tally[pos] != TALLY_MAX) begin
                        dist_tally[pos] = dist_tally[pos] + 1'b1;
                    end
                    res.counted  = 1'b1;
                    res.distance = DIST_W'(pos);
                end
            end
            CMD_MARKER: marker_flag = 1'b1;
            CMD_READ:   res.count = OUT_COUNT_W'(dist_tally[sel]);
            default: ;
        endcase
        return res;
    endfunction

    // Sends one item in bursts with random gaps between them, and books the
    // result that it owes once the block has taken it.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] addr,
                             input logic [SEL_W-1:0] sel);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_access_address <= addr;
        i_bin_select     <= sel;
        do @(posedge i_clk); while (!o_in_ready);
        due_outcomes.push_back(lru_outcome(cmd, addr, sel));
        items_sent++;
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (due_outcomes.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LINE_SHIFT) begin
            shift_cfg = data[SHIFT_W-1:0];
        end else if (idx == CFG_WAIT_MARKER) begin
            gate_cfg = data[0];
        end
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Accesses are dropped until the first marker; after it they are binned.
    task automatic test_marker_gate();
        write_reg(CFG_WAIT_MARKER, 8'd1);
        send_item(CMD_ACCESS, '0, 8'hFF);
        send_item(CMD_ACCESS, '1, 8'h00);
        send_item(CMD_READ, rand_addr(), 8'hFF);
        send_item(CMD_UNUSED, '1, 8'hFF);
        send_item(CMD_MARKER, rand_addr(), 8'h5A);
        send_item(CMD_MARKER, '1, 8'hFF);
        send_item(CMD_ACCESS, '0, 8'h00);
        send_item(CMD_ACCESS, 64'h3F, 8'h00);
        send_item(CMD_READ, '0, 8'h00);
        send_item(CMD_READ, '1, 8'hFF);
        drain_results();
        write_reg(CFG_WAIT_MARKER, 8'hFE);
    endtask

    // Extremes of the line shift, undecoded register indexes, and read-outs.
    task automatic test_field_extremes();
        write_reg(CFG_LINE_SHIFT, 8'd0);
        send_item(CMD_ACCESS, '1, 8'h00);
        send_item(CMD_ACCESS, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00);
        send_item(CMD_ACCESS, '1, 8'h00);
        drain_results();
        write_reg(CFG_LINE_SHIFT, 8'h0F);
        send_item(CMD_ACCESS, '0, 8'h00);
        send_item(CMD_ACCESS, 64'h7FFF, 8'h00);
        drain_results();
        // Only the low four bits of the data count: this sets a shift of 12.
        write_reg(CFG_LINE_SHIFT, 8'hFC);
        write_reg(CFG_SPARE_IDX, 8'hFF);
        write_reg(CFG_TOP_IDX, 8'h00);
        send_item(CMD_ACCESS, 64'h1000, 8'h00);
        send_item(CMD_ACCESS, 64'h1FFF, 8'h00);
        send_item(CMD_READ, '1, 8'h00);
        send_item(CMD_READ, '0, 8'h01);
        send_item(CMD_READ, '0, 8'h80);
        send_item(CMD_READ, '0, 8'hFF);
        send_item(CMD_UNUSED, '0, 8'h00);
        drain_results();
    endtask

    // Touches 256 distinct lines, so the first has fallen off the stack and
    // the second sits at its deepest place, then reuses both.
    task automatic test_deep_reuse();
        logic [LINE_W-1:0] base;
        base    = rand_addr();
        gap_max = 3;
        write_reg(CFG_LINE_SHIFT, 8'd6);
        for (int i = 0; i < HIST_BINS; i++) begin
            send_item(CMD_ACCESS, {base[LINE_W-1:14], 8'(i), 6'($urandom)}, 8'($urandom));
        end
        send_item(CMD_ACCESS, {base[LINE_W-1:14], 8'd1, 6'($urandom)}, 8'h00);
        send_item(CMD_ACCESS, {base[LINE_W-1:14], 8'd0, 6'($urandom)}, 8'h00);
        send_item(CMD_ACCESS, {base[LINE_W-1:14], 8'd255, 6'($urandom)}, 8'h00);
        send_item(CMD_READ, rand_addr(), 8'd254);
        send_item(CMD_READ, rand_addr(), 8'd255);
        send_item(CMD_READ, rand_addr(), 8'd0);
        drain_results();
    endtask

    // Mixed traffic over a pool of hot addresses under one register setting.
    task automatic test_random_phase(input logic [CFG_DATA_W-1:0] shift_data,
                                     input logic [CFG_DATA_W-1:0] gate_data,
                                     input int pool, input int gaps, input int count,
                                     input bit mid_pause);
        int                pick;
        logic [LINE_W-1:0] addr;
        write_reg(CFG_LINE_SHIFT, shift_data);
        write_reg(CFG_WAIT_MARKER, gate_data);
        hot_count = pool;
        gap_max   = gaps;
        for (int i = 0; i < hot_count; i++) hot_addrs[i] = rand_addr();
        for (int n = 0; n < count; n++) begin
            if (mid_pause && n == count / 2) begin
                drain_results();
            end
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                if ($urandom_range(4, 0) == 0) begin
                    addr = rand_addr();
                end else begin
                    // Flip a few low bits so that lines are hit at varied offsets.
                    addr = hot_addrs[$urandom_range(hot_count - 1, 0)] ^ LINE_W'($urandom_range(63, 0));
                end
                send_item(CMD_ACCESS, addr, 8'($urandom));
            end else if (pick < 90) begin
                send_item(CMD_READ, rand_addr(),
                          ($urandom_range(1, 0) != 0) ? 8'($urandom_range(31, 0)) : 8'($urandom));
            end else if (pick < 95) begin
                send_item(CMD_MARKER, rand_addr(), 8'($urandom));
            end else begin
                send_item(CMD_UNUSED, rand_addr(), 8'($urandom));
            end
        end
        drain_results();
    endtask

    // Receiver: switches between always ready, random stalls and long stalls.
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(2, 0);
            rx_hold <= $urandom_range(400, 40);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(1, 0) != 0);
            default: i_out_ready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    // Compares every result taken with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (due_outcomes.size() == 0) begin
                $error("result with none owed: counted %0d distance %0d count %0d",
                       o_counted, o_reuse_distance, o_bin_count);
                mismatches++;
            end else begin
                want = due_outcomes.pop_front();
                if (o_counted !== want.counted) begin
                    $error("counted: expected %0d, got %0d", want.counted, o_counted);
                    mismatches++;
                end
                if (o_reuse_distance !== want.distance) begin
                    $error("reuse_distance: expected %0d, got %0d", want.distance,
                           o_reuse_distance);
                    mismatches++;
                end
                if (o_bin_count !== want.count) begin
                    $error("bin_count: expected %0d, got %0d", want.count, o_bin_count);
                    mismatches++;
                end
                if (want.counted) begin
                    accesses_bin++;
                    if (int'(want.distance) > deepest_dist) deepest_dist = int'(want.distance);
                end
            end
        end
    end

    // Ends the run when nothing has moved on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            mru_lines[i] = '0;
            mru_live[i]  = 1'b0;
        end
        for (int i = 0; i < HIST_BINS; i++) dist_tally[i] = '0;
        marker_flag = 1'b0;
        shift_cfg   = LINE_SHIFT_RESET;
        gate_cfg    = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_marker_gate();
        test_field_extremes();
        test_deep_reuse();
        test_random_phase(8'd6,  8'd0, 12,  0, 120, 1'b0);
        test_random_phase(8'd0,  8'd1, 200, 4, 120, 1'b1);
        test_random_phase(8'd15, 8'd0, 32,  8, 120, 1'b0);
        test_random_phase(8'($urandom_range(15, 0)), 8'd1, 64, 2, 120, 1'b0);

        drain_results();
        repeat (HIST_BINS + 40) @(posedge i_clk);

        $display("run: %0d items over %0d register writes, %0d results checked",
                 items_sent, reg_writes, results_seen);
        $display("run: %0d accesses binned, deepest reuse distance %0d",
                 accesses_bin, deepest_dist);
        if (mismatches == 0 && due_outcomes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
